>>> rtl/http_request_head_parser_defines.svh
// assertion macros for the request head parser checker
`ifndef HTTP_REQUEST_HEAD_PARSER_DEFINES_SVH
`define HTTP_REQUEST_HEAD_PARSER_DEFINES_SVH

// plain implication check, reset disables it
`define HRP_ASSERT_IMP(label, clk, rst_n, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

// next-cycle implication check
`define HRP_ASSERT_NXT(label, clk, rst_n, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

>>> rtl/hrp_pkg.sv
package hrp_pkg;

  localparam int LENGTH_BITS = 32;

  typedef enum logic [11:0] {
    PH_PRE_METHOD   = 12'h001,
    PH_METHOD       = 12'h002,
    PH_PRE_PATH     = 12'h004,
    PH_PATH         = 12'h008,
    PH_QUERY        = 12'h010,
    PH_PRE_VERSION  = 12'h020,
    PH_VERSION      = 12'h040,
    PH_AFTER_VER    = 12'h080,
    PH_HDR_NAME     = 12'h100,
    PH_HDR_VALUE    = 12'h200,
    PH_BODY         = 12'h400,
    PH_DONE         = 12'h800
  } phase_t;

  typedef enum logic [3:0] {
    DG_BEFORE = 4'b0001,
    DG_SIGN   = 4'b0010,
    DG_DIGITS = 4'b0100,
    DG_AFTER  = 4'b1000
  } digit_t;

  localparam logic [3:0] ROLE_NONE    = 4'd0;
  localparam logic [3:0] ROLE_METHOD  = 4'd1;
  localparam logic [3:0] ROLE_PATH    = 4'd2;
  localparam logic [3:0] ROLE_QUERY   = 4'd3;
  localparam logic [3:0] ROLE_VERSION = 4'd4;
  localparam logic [3:0] ROLE_HNAME   = 4'd5;
  localparam logic [3:0] ROLE_HVALUE  = 4'd6;
  localparam logic [3:0] ROLE_EOL     = 4'd7;
  localparam logic [3:0] ROLE_BODY    = 4'd8;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_REQLINE  = 3'd1;
  localparam logic [2:0] ERR_VERSION  = 3'd2;
  localparam logic [2:0] ERR_COLON    = 3'd3;
  localparam logic [2:0] ERR_LENGTH   = 3'd4;
  localparam logic [2:0] ERR_BARE_CR  = 3'd5;

  localparam logic [2:0] METH_UNKNOWN = 3'd7;
  localparam logic [1:0] VER_HTTP2    = 2'd2;
  localparam logic [1:0] VER_UNKNOWN  = 2'd3;

  localparam logic [1:0] ST_BUSY  = 2'd0;
  localparam logic [1:0] ST_DONE  = 2'd1;
  localparam logic [1:0] ST_ERROR = 2'd2;

  // parsed fields of one result
  typedef struct packed {
    logic [3:0]  role;
    logic [7:0]  data;
    logic [2:0]  meth;
    logic [1:0]  ver;
    logic [31:0] blen;
    logic [1:0]  status;
    logic [2:0]  err;
  } result_t;

  function automatic logic [3:0] meth_len(input logic [2:0] i);
    case (i)
      3'd0: return 4'd3;
      3'd1: return 4'd4;
      3'd2: return 4'd3;
      3'd3: return 4'd6;
      3'd4: return 4'd5;
      3'd5: return 4'd4;
      default: return 4'd7;
    endcase
  endfunction

  // method name character at a position, 0 beyond its end
  function automatic logic [7:0] meth_chr(input logic [2:0] i, input logic [3:0] p);
    logic [63:0] s;
    case (i)
      3'd0: s = {"GET", 40'd0};
      3'd1: s = {"POST", 32'd0};
      3'd2: s = {"PUT", 40'd0};
      3'd3: s = {"DELETE", 16'd0};
      3'd4: s = {"PATCH", 24'd0};
      3'd5: s = {"HEAD", 32'd0};
      default: s = {"OPTIONS", 8'd0};
    endcase
    return (p < meth_len(i)) ? s[63 - 8 * int'(p[2:0]) -: 8] : 8'd0;
  endfunction

  function automatic logic [3:0] ver_len(input logic [1:0] i);
    return (i == 2'd3) ? 4'd6 : 4'd8;
  endfunction

  function automatic logic [7:0] ver_chr(input logic [1:0] i, input logic [3:0] p);
    logic [63:0] s;
    case (i)
      2'd0: s = "HTTP/1.0";
      2'd1: s = "HTTP/1.1";
      2'd2: s = "HTTP/2.0";
      default: s = {"HTTP/2", 16'd0};
    endcase
    return (p < ver_len(i)) ? s[63 - 8 * int'(p[2:0]) -: 8] : 8'd0;
  endfunction

  function automatic logic [7:0] lname_chr(input logic i, input logic [3:0] p);
    logic [127:0] s;
    s = i ? {"content-length", 16'd0} : {"Content-Length", 16'd0};
    return (p < 4'd14) ? s[127 - 8 * int'(p) -: 8] : 8'd0;
  endfunction

  function automatic logic is_blank(input logic [7:0] b);
    return (b == 8'h20) || (b == 8'h09) || (b == 8'h0B) || (b == 8'h0C);
  endfunction

endpackage

>>> rtl/hrp_matcher.sv
// candidate narrowing for method, version and length-header names
module hrp_matcher (
  input  logic [3:0] pos,
  input  logic [7:0] b,
  input  logic [6:0] meth_in,
  input  logic [3:0] ver_in,
  input  logic [1:0] lname_in,
  output logic [6:0] meth_out,
  output logic [3:0] ver_out,
  output logic [1:0] lname_out
);
  import hrp_pkg::*;

  // drop each candidate whose name does not continue with this byte
  always_comb begin
    for (int i = 0; i < 7; i++)
      meth_out[i] = meth_in[i] && (pos < meth_len(3'(i))) && (meth_chr(3'(i), pos) == b);
    for (int i = 0; i < 4; i++)
      ver_out[i] = ver_in[i] && (pos < ver_len(2'(i))) && (ver_chr(2'(i), pos) == b);
    for (int i = 0; i < 2; i++)
      lname_out[i] = lname_in[i] && (pos < 4'd14) && (lname_chr(1'(i), pos) == b);
  end

endmodule

>>> rtl/http_request_head_parser.sv
// channel | dir | payload
// in_     | in  | tuser: start_request; tdata: data_byte
// out_    | out | tdata: byte_role, echo_byte, method_code, version_code,
//         |     |        body_length, parse_status, error_kind
// one byte per cycle while the output is not stalled, one result per byte,
// registered into the output register; the parse state updates in the same cycle.
// rst_n synchronous active low; clears all parse state and the output valid.
// a stalled output takes a new byte only when the register is freed that cycle.
module http_request_head_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte
  input  logic        in_tuser,   // start_request
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata   // role[3:0] byte[11:4] meth[14:12] ver[16:15]
                                  // len[48:17] status[50:49] err[53:51]
);
  import hrp_pkg::*;

  phase_t      ph_r, ph_nxt;
  logic [3:0]  pos_r, pos_nxt;
  logic [6:0]  mc_r, mc_nxt;
  logic [3:0]  vc_r, vc_nxt;
  logic [1:0]  lc_r, lc_nxt;
  logic [2:0]  mres_r, mres_nxt;
  logic [1:0]  vres_r, vres_nxt;
  logic [LENGTH_BITS-1:0] acc_r, acc_nxt;
  logic [LENGTH_BITS-1:0] rem_r, rem_nxt;
  digit_t      dg_r, dg_nxt;
  logic        crp_r, crp_nxt;
  logic        le_r, le_nxt;
  logic [2:0]  err_r, err_nxt;
  logic        ov_r;
  result_t     res_r, res_nxt;

  // start-of-request view of the state
  phase_t      ph0;
  logic [3:0]  pos0;
  logic [6:0]  mc0;
  logic [3:0]  vc0;
  logic [1:0]  lc0;
  logic [2:0]  mres0;
  logic [1:0]  vres0;
  logic [LENGTH_BITS-1:0] acc0, rem0;
  digit_t      dg0;
  logic        crp0, le0;
  logic [2:0]  err0;

  logic [3:0]  mpos;
  logic [6:0]  min_m, mout;
  logic [3:0]  vin_m, vout;
  logic [1:0]  lout;
  logic [7:0]  b;
  logic        take;
  logic [3:0]  dval;
  logic [LENGTH_BITS+3:0] prod;

  assign b = in_tdata;
  assign in_tready = !ov_r || out_tready;
  assign take = in_tvalid && in_tready;

  always_comb begin
    if (in_tuser) begin
      ph0 = PH_PRE_METHOD; pos0 = '0; mc0 = '1; vc0 = '1; lc0 = '1;
      mres0 = METH_UNKNOWN; vres0 = VER_UNKNOWN; acc0 = '0; rem0 = '0;
      dg0 = DG_BEFORE; crp0 = 1'b0; le0 = 1'b1; err0 = ERR_NONE;
    end else begin
      ph0 = ph_r; pos0 = pos_r; mc0 = mc_r; vc0 = vc_r; lc0 = lc_r;
      mres0 = mres_r; vres0 = vres_r; acc0 = acc_r; rem0 = rem_r;
      dg0 = dg_r; crp0 = crp_r; le0 = le_r; err0 = err_r;
    end
  end

  // method or version token entry resets position and candidates before matching
  always_comb begin
    mpos  = pos0;
    min_m = mc0;
    vin_m = vc0;
    if (ph0 == PH_PRE_METHOD) begin
      mpos = '0; min_m = '1;
    end
    if (ph0 == PH_PRE_VERSION) begin
      mpos = '0; vin_m = '1;
    end
  end

  hrp_matcher u_match (
    .pos(mpos), .b(b), .meth_in(min_m), .ver_in(vin_m), .lname_in(lc0),
    .meth_out(mout), .ver_out(vout), .lname_out(lout)
  );

  assign dval = b[3:0] - 4'd0;
  assign prod = {4'd0, acc0} * {{LENGTH_BITS{1'b0}}, 4'd10} + {{LENGTH_BITS{1'b0}}, dval};

  // per-byte parse step
  always_comb begin
    logic [3:0] role;
    logic       eol;
    logic       digit;
    ph_nxt = ph0; pos_nxt = pos0; mc_nxt = mc0; vc_nxt = vc0; lc_nxt = lc0;
    mres_nxt = mres0; vres_nxt = vres0; acc_nxt = acc0; rem_nxt = rem0;
    dg_nxt = dg0; crp_nxt = crp0; le_nxt = le0; err_nxt = err0;
    role = ROLE_NONE;
    eol = 1'b0;
    digit = (b >= 8'h30) && (b <= 8'h39);
    if (err0 == ERR_NONE && ph0 != PH_DONE) begin
      if (ph0 == PH_BODY) begin
        role = ROLE_BODY;
        rem_nxt = rem0 - LENGTH_BITS'(1);
        if (rem_nxt == '0) ph_nxt = PH_DONE;
      end else if (crp0) begin
        crp_nxt = 1'b0;
        if (b == 8'h0A) begin
          role = ROLE_EOL; eol = 1'b1;
        end else err_nxt = ERR_BARE_CR;
      end else if (b == 8'h0D) begin
        crp_nxt = 1'b1; role = ROLE_EOL;
      end else if (b == 8'h0A) begin
        role = ROLE_EOL; eol = 1'b1;
      end else begin
        le_nxt = 1'b0;
        unique case (ph0) inside
          PH_PRE_METHOD, PH_METHOD: begin
            if (is_blank(b)) begin
              if (ph0 == PH_METHOD) begin
                mres_nxt = METH_UNKNOWN;
                for (int i = 0; i < 7; i++)
                  if (mc0[i] && meth_len(3'(i)) == pos0) mres_nxt = 3'(i);
                ph_nxt = PH_PRE_PATH;
              end
            end else begin
              ph_nxt = PH_METHOD;
              mc_nxt = mout;
              pos_nxt = (mpos == 4'd15) ? mpos : mpos + 4'd1;
              role = ROLE_METHOD;
            end
          end
          PH_PRE_PATH, PH_PATH: begin
            if (is_blank(b)) begin
              if (ph0 == PH_PATH) ph_nxt = PH_PRE_VERSION;
            end else if (b == 8'h3F) ph_nxt = PH_QUERY;
            else begin
              ph_nxt = PH_PATH; role = ROLE_PATH;
            end
          end
          PH_QUERY: begin
            if (is_blank(b)) ph_nxt = PH_PRE_VERSION;
            else role = ROLE_QUERY;
          end
          PH_PRE_VERSION, PH_VERSION: begin
            if (is_blank(b)) begin
              if (ph0 == PH_VERSION) begin
                vres_nxt = VER_UNKNOWN;
                for (int i = 0; i < 4; i++)
                  if (vc0[i] && ver_len(2'(i)) == pos0)
                    vres_nxt = (i == 3) ? VER_HTTP2 : 2'(i);
                ph_nxt = PH_AFTER_VER;
              end
            end else begin
              ph_nxt = PH_VERSION;
              vc_nxt = vout;
              pos_nxt = (mpos == 4'd15) ? mpos : mpos + 4'd1;
              role = ROLE_VERSION;
            end
          end
          PH_HDR_NAME: begin
            if (b == 8'h3A) begin
              if (pos0 != 4'd14) lc_nxt = '0;
              if (lc_nxt != '0) acc_nxt = '0;
              ph_nxt = PH_HDR_VALUE; pos_nxt = '0; dg_nxt = DG_BEFORE;
            end else begin
              lc_nxt = lout;
              pos_nxt = (pos0 == 4'd15) ? pos0 : pos0 + 4'd1;
              role = ROLE_HNAME;
            end
          end
          PH_HDR_VALUE: begin
            if (!(pos0 == '0 && (b == 8'h20 || b == 8'h09))) begin
              pos_nxt = 4'd1; role = ROLE_HVALUE;
            end
            if (lc0 != '0 && dg0 != DG_AFTER) begin
              if (digit) begin
                if (prod[LENGTH_BITS+3:LENGTH_BITS] != '0) err_nxt = ERR_LENGTH;
                else begin
                  acc_nxt = prod[LENGTH_BITS-1:0]; dg_nxt = DG_DIGITS;
                end
              end else if (dg0 == DG_DIGITS) dg_nxt = DG_AFTER;
              else if (dg0 == DG_BEFORE && is_blank(b)) dg_nxt = DG_BEFORE;
              else if (dg0 == DG_BEFORE && b == 8'h2B) dg_nxt = DG_SIGN;
              else err_nxt = ERR_LENGTH;
            end
          end
          default: ;
        endcase
      end
      // line end handling
      if (eol) begin
        unique case (ph0) inside
          PH_PRE_METHOD, PH_METHOD, PH_PRE_PATH: err_nxt = ERR_REQLINE;
          PH_PATH, PH_QUERY, PH_PRE_VERSION: err_nxt = ERR_VERSION;
          PH_VERSION, PH_AFTER_VER: begin
            if (ph0 == PH_VERSION) begin
              vres_nxt = VER_UNKNOWN;
              for (int i = 0; i < 4; i++)
                if (vc0[i] && ver_len(2'(i)) == pos0)
                  vres_nxt = (i == 3) ? VER_HTTP2 : 2'(i);
            end
            ph_nxt = PH_HDR_NAME; pos_nxt = '0; lc_nxt = '1; le_nxt = 1'b1;
          end
          PH_HDR_NAME: begin
            if (!le0) err_nxt = ERR_COLON;
            else begin
              rem_nxt = acc0;
              ph_nxt = (acc0 == '0) ? PH_DONE : PH_BODY;
            end
          end
          PH_HDR_VALUE: begin
            if (lc0 != '0 && (dg0 == DG_BEFORE || dg0 == DG_SIGN)) err_nxt = ERR_LENGTH;
            else begin
              ph_nxt = PH_HDR_NAME; pos_nxt = '0; lc_nxt = '1; le_nxt = 1'b1;
            end
          end
          default: ;
        endcase
      end
      if (err_nxt != ERR_NONE) role = ROLE_NONE;
    end
    res_nxt.role = role;
    res_nxt.data = b;
    res_nxt.meth = mres_nxt;
    res_nxt.ver = vres_nxt;
    res_nxt.blen = 32'(acc_nxt);
    res_nxt.status = (err_nxt != ERR_NONE) ? ST_ERROR : ((ph_nxt == PH_DONE) ? ST_DONE : ST_BUSY);
    res_nxt.err = err_nxt;
  end

  // state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= PH_PRE_METHOD; pos_r <= '0; mc_r <= '1; vc_r <= '1; lc_r <= '1;
      mres_r <= METH_UNKNOWN; vres_r <= VER_UNKNOWN; acc_r <= '0; rem_r <= '0;
      dg_r <= DG_BEFORE; crp_r <= 1'b0; le_r <= 1'b1; err_r <= ERR_NONE;
      ov_r <= 1'b0;
    end else begin
      if (take) begin
        ph_r <= ph_nxt; pos_r <= pos_nxt; mc_r <= mc_nxt; vc_r <= vc_nxt;
        lc_r <= lc_nxt; mres_r <= mres_nxt; vres_r <= vres_nxt; acc_r <= acc_nxt;
        rem_r <= rem_nxt; dg_r <= dg_nxt; crp_r <= crp_nxt; le_r <= le_nxt;
        err_r <= err_nxt;
        ov_r <= 1'b1;
      end else if (out_tready) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) res_r <= res_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata = {2'b00, res_r.err, res_r.status, res_r.blen, res_r.ver,
                      res_r.meth, res_r.data, res_r.role};

endmodule

>>> rtl/hrp_checker.sv
`include "http_request_head_parser_defines.svh"
module hrp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [7:0]  in_tdata,
  input logic        in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata
);
  import hrp_pkg::*;

  logic [3:0] role;
  logic [1:0] status;
  logic [2:0] kind;
  logic       in_take;

  assign role = out_tdata[3:0];
  assign status = out_tdata[50:49];
  assign kind = out_tdata[53:51];
  assign in_take = in_tvalid && in_tready && (in_tuser || !in_tuser);

  // echoed byte matches the input byte taken in the cycle before
  `HRP_ASSERT_NXT(a_echo, clk, rst_n, in_take, out_tdata[11:4] == $past(in_tdata), "echo mismatch")
  // an error result carries a kind and role none
  `HRP_ASSERT_IMP(a_err, clk, rst_n, out_tvalid && status == ST_ERROR, kind != ERR_NONE && role == ROLE_NONE, "error without kind")
  // no error kind while not in error
  `HRP_ASSERT_IMP(a_noerr, clk, rst_n, out_tvalid && status != ST_ERROR, kind == ERR_NONE, "stray error kind")
  // stalled output holds
  `HRP_ASSERT_NXT(a_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "output dropped")
  // ready whenever output is empty
  `HRP_ASSERT_IMP(a_rdy, clk, rst_n, !out_tvalid, in_tready, "not ready while empty")
endmodule

bind http_request_head_parser hrp_checker u_hrp_checker (.*);
